// File: hw/rtl/cmga_pkg.sv
`default_nettype none
package cmga_pkg;

   localparam int MAX_STATIONS = 16;
   localparam int STN_W        = 4;
   localparam int CNT_W        = 5;
   localparam int POS_W        = 40;
   localparam int DIFF_W       = POS_W + 1;
   localparam int SUM_W        = 64;
   localparam int MASS_W       = 56;
   localparam int SAT_W        = 18;
   localparam int FRAC_W       = 17;
   localparam int DEN_W        = 16;
   localparam int PV_W         = 32;
   localparam int WDEN_W       = 34;
   localparam int D2_W         = 84;
   localparam int FRAC_EXTRA   = 17;
   localparam int GRAV_SCALE   = 6670;

   localparam int MUL_A_W      = 128;
   localparam int MUL_B_W      = 64;
   localparam int MUL_DIGIT_W  = 8;
   localparam int MUL_STEPS    = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W    = $clog2(MUL_STEPS);

   localparam int ROOT_W       = 44;
   localparam int SQRT_X_W     = 2 * ROOT_W;
   localparam int SQRT_REM_W   = ROOT_W + 4;
   localparam int SQRT_CNT_W   = $clog2(ROOT_W);
   localparam int RAD_W        = 42;

   localparam int DIV_W        = 128;
   localparam int DIV_CNT_W    = $clog2(DIV_W);

   localparam logic [FRAC_W-1:0] SAT_ONE = FRAC_W'(65536);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_CELL1 = 2'd1,
      CMD_CELL2 = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_HAS_GAS   = 2'd0;
   localparam logic [1:0] CSR_HAS_OIL   = 2'd1;
   localparam logic [1:0] CSR_GAS_GIVEN = 2'd2;
   localparam logic [1:0] CSR_COUNT     = 2'd3;

   localparam logic STATUS_DATA  = 1'b0;
   localparam logic STATUS_FAULT = 1'b1;

   typedef struct packed {
      logic signed [POS_W-1:0] east;
      logic signed [POS_W-1:0] north;
      logic signed [POS_W-1:0] depth;
      logic signed [SUM_W-1:0] sum;
   } station_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEEK,
      ST_MO,
      ST_MG,
      ST_MW,
      ST_MPV,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_SQZ,
      ST_SQRT,
      ST_AZK,
      ST_NUM,
      ST_D3,
      ST_DIV,
      ST_ACC,
      ST_NEXT,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// File: hw/rtl/cmga_cell.sv
`default_nettype none
module cmga_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift,
   input  wire logic                  wr,
   input  wire cmga_pkg::station_type wr_data,
   input  wire cmga_pkg::station_type nb_in,
   output cmga_pkg::station_type      q
);

   cmga_pkg::station_type stn_ff, stn_in;

   always_comb begin
      stn_in = stn_ff;
      if (shift) begin
         stn_in = nb_in;
      end else if (wr) begin
         stn_in = wr_data;
      end
   end

   // sum resets to zero, position stays undefined until loaded
   always_ff @(posedge clock) begin
      stn_ff.east  <= stn_in.east;
      stn_ff.north <= stn_in.north;
      stn_ff.depth <= stn_in.depth;
      if (reset) begin
         stn_ff.sum <= '0;
      end else begin
         stn_ff.sum <= stn_in.sum;
      end
   end

   assign q = stn_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cmga_mul.sv
`default_nettype none
module cmga_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [cmga_pkg::MUL_A_W-1:0]   a,
   input  wire logic [cmga_pkg::MUL_B_W-1:0]   b,
   output logic                                done,
   output logic [cmga_pkg::MUL_A_W-1:0]        product
);

   localparam int AW = cmga_pkg::MUL_A_W;
   localparam int BW = cmga_pkg::MUL_B_W;
   localparam int DW = cmga_pkg::MUL_DIGIT_W;

   logic [AW-1:0]                    acc_ff, acc_in, a_ff, a_in;
   logic [BW-1:0]                    b_ff, b_in;
   logic [cmga_pkg::MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic [AW+DW-1:0]                 part;

   always_comb begin
      part    = {{DW{1'b0}}, a_ff} * {{AW{1'b0}}, b_ff[DW-1:0]};
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part[AW-1:0];
         a_in   = a_ff << DW;
         b_in   = b_ff >> DW;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cmga_pkg::MUL_CNT_W'(cmga_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cmga_sqrt.sv
`default_nettype none
module cmga_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [cmga_pkg::SQRT_X_W-1:0]   x,
   output logic                                 done,
   output logic [cmga_pkg::ROOT_W-1:0]          root
);

   localparam int XW = cmga_pkg::SQRT_X_W;
   localparam int RW = cmga_pkg::ROOT_W;
   localparam int MW = cmga_pkg::SQRT_REM_W;

   logic [XW-1:0]                    x_ff, x_in;
   logic [MW-1:0]                    rem_ff, rem_in, rem_sh, trial;
   logic [RW-1:0]                    root_ff, root_in;
   logic [cmga_pkg::SQRT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                             busy_ff, busy_in, done_ff, done_in;

   // restoring digit recurrence, one root bit per cycle
   always_comb begin
      rem_sh  = {rem_ff[MW-3:0], x_ff[XW-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = x_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cmga_pkg::SQRT_CNT_W'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cmga_div.sv
`default_nettype none
module cmga_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [cmga_pkg::DIV_W-1:0]    num,
   input  wire logic [cmga_pkg::DIV_W-1:0]    den,
   output logic                               done,
   output logic [cmga_pkg::SUM_W-1:0]         quot
);

   localparam int W  = cmga_pkg::DIV_W;
   localparam int QW = cmga_pkg::SUM_W;

   logic [W-1:0]                    n_ff, n_in, d_ff, d_in, q_ff, q_in;
   logic [W:0]                      rem_ff, rem_in, rem_sh;
   logic [cmga_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in, done_ff, done_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff[W-1:0], n_ff[W-1]};
      n_in    = n_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = num;
         d_in    = den;
         q_in    = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_in = rem_sh - {1'b0, d_ff};
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cmga_pkg::DIV_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // saturate to the largest positive 64-bit value
   assign quot = (q_ff[W-1:QW-1] != '0) ? {1'b0, {(QW-1){1'b1}}} : q_ff[QW-1:0];
   assign done = done_ff;

endmodule
`default_nettype wire

// File: hw/rtl/cell_mass_gravity_accumulator.sv
`default_nettype none
// Channel  Ports                       Direction  Moves
// req      req_valid / req_ready       in         one command per transfer
// rsp      rsp_valid / rsp_ready       out        read data or fault per transfer
// csr      csr_we / csr_index / csr_wdata  in     register write, no back-pressure
//
// One item at a time. Load and read each include up to 15 ring rotations.
// Cell item: the mass takes four passes of the 8-digit multiplier.
// Second cell item adds up to 15 rotations and a pass through the arithmetic per station,
// dominated by the 128-step divider and the 44-step square root.
// Synchronous reset clears station sums, first mass and registers; no clearing pass.
// A result waiting on rsp holds only a further result, not the next transfer in.
module cell_mass_gravity_accumulator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_command,
   input  wire logic [cmga_pkg::STN_W-1:0]           req_station_index,
   input  wire logic signed [cmga_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [cmga_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [cmga_pkg::POS_W-1:0]    req_pos_z,
   input  wire logic signed [cmga_pkg::SAT_W-1:0]    req_water_sat,
   input  wire logic signed [cmga_pkg::SAT_W-1:0]    req_gas_sat,
   input  wire logic [cmga_pkg::DEN_W-1:0]           req_oil_density,
   input  wire logic [cmga_pkg::DEN_W-1:0]           req_gas_density,
   input  wire logic [cmga_pkg::DEN_W-1:0]           req_water_density,
   input  wire logic [cmga_pkg::PV_W-1:0]            req_pore_volume,
   input  wire logic                                 req_aquifer_cell,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [cmga_pkg::STN_W-1:0]                rsp_result_station,
   output logic signed [cmga_pkg::SUM_W-1:0]         rsp_gravity_change,
   output logic                                      rsp_status,
   input  wire logic                                 csr_we,
   input  wire logic [1:0]                           csr_index,
   input  wire logic [cmga_pkg::CNT_W-1:0]           csr_wdata
);

   localparam int NS  = cmga_pkg::MAX_STATIONS;
   localparam int SW  = cmga_pkg::STN_W;
   localparam int PW  = cmga_pkg::POS_W;
   localparam int DFW = cmga_pkg::DIFF_W;
   localparam int FW  = cmga_pkg::FRAC_W;
   localparam int MSW = cmga_pkg::MASS_W;
   localparam int D2W = cmga_pkg::D2_W;
   localparam int AW  = cmga_pkg::MUL_A_W;
   localparam int BW  = cmga_pkg::MUL_B_W;
   localparam int UW  = cmga_pkg::SUM_W;
   localparam int RW  = cmga_pkg::ROOT_W;
   localparam int RDW = cmga_pkg::RAD_W;

   function automatic logic [FW-1:0] clamp_sat(input logic [cmga_pkg::SAT_W-1:0] s);
      if (s[cmga_pkg::SAT_W-1]) begin
         return '0;
      end else if (s[FW-1:0] > cmga_pkg::SAT_ONE) begin
         return cmga_pkg::SAT_ONE;
      end else begin
         return s[FW-1:0];
      end
   endfunction

   cmga_pkg::state_type state_ff, state_in;
   logic                launch_ff;

   logic                        has_gas_ff, has_gas_in, has_oil_ff, has_oil_in;
   logic                        gas_given_ff, gas_given_in;
   logic [cmga_pkg::CNT_W-1:0]  count_ff, count_in;

   cmga_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [SW-1:0]                     idx_ff, idx_in, tgt_ff, tgt_in;
   logic signed [PW-1:0]              px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [cmga_pkg::SAT_W-1:0]        swr_ff, swr_in, sgr_ff, sgr_in;
   logic [cmga_pkg::DEN_W-1:0]        od_ff, od_in, gd_ff, gd_in, wd_ff, wd_in;
   logic [cmga_pkg::PV_W-1:0]         pv_ff, pv_in;

   logic [SW-1:0]                     head_ff, head_in, stn_ff, stn_in;
   logic [cmga_pkg::CNT_W-1:0]        n_ff, n_in;
   logic [cmga_pkg::WDEN_W-1:0]       w_ff, w_in;
   logic [MSW-1:0]                    first_ff, first_in, dm_mag_ff, dm_mag_in;
   logic                              dm_neg_ff, dm_neg_in, dz_neg_ff, dz_neg_in;
   logic [DFW-1:0]                    ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [D2W-1:0]                    d2_ff, d2_in, d2_sum;
   logic [RDW-1:0]                    r_ff, r_in;
   logic [BW-1:0]                     azk_ff, azk_in;
   logic [AW-1:0]                     num_ff, num_in, d3_ff, d3_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                     rsp_stn_ff, rsp_stn_in, res_stn_ff, res_stn_in;
   logic signed [UW-1:0]              rsp_gc_ff, rsp_gc_in, res_gc_ff, res_gc_in;
   logic                              rsp_st_ff, rsp_st_in, res_st_ff, res_st_in;

   logic [FW-1:0]                     sw_c, sg_c, so_c;
   logic signed [FW+1:0]              so_rem;
   logic [MSW-1:0]                    mass;
   logic signed [MSW:0]               dm;
   logic signed [DFW-1:0]             dx, dy, dz;
   logic signed [UW:0]                term;
   logic signed [UW+1:0]              acc_sum;
   logic signed [UW-1:0]              new_sum;
   logic [RW:0]                       root_p1;

   cmga_pkg::station_type             stn_q [NS];
   cmga_pkg::station_type             head, wr_data;
   logic                              shift_ring, wr_head;

   logic                              mul_start, mul_done, sqrt_start, sqrt_done;
   logic                              div_start, div_done;
   logic [AW-1:0]                     mul_a, mul_p;
   logic [BW-1:0]                     mul_b;
   logic [RW-1:0]                     root;
   logic [UW-1:0]                     div_quot;
   logic                              mul_state;

   for (genvar i = 0; i < NS; i++) begin : g_ring
      localparam int Nxt = (i + 1) % NS;
      cmga_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift_ring),
         .wr      ((i == 0) && wr_head),
         .wr_data (wr_data),
         .nb_in   (stn_q[Nxt]),
         .q       (stn_q[i])
      );
   end

   assign head = stn_q[0];

   cmga_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   cmga_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .x     ({2'b00, d2_ff, 2'b00}),
      .done  (sqrt_done),
      .root  (root)
   );

   cmga_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff << cmga_pkg::FRAC_EXTRA),
      .den   (d3_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // phase fractions
   always_comb begin
      sw_c = clamp_sat(swr_ff);
      sg_c = '0;
      so_c = '0;
      if (has_gas_ff) begin
         sg_c = gas_given_ff ? clamp_sat(sgr_ff) : cmga_pkg::SAT_ONE - sw_c;
      end
      so_rem = $signed({2'b00, cmga_pkg::SAT_ONE}) - $signed({2'b00, sg_c})
             - $signed({2'b00, sw_c});
      if (has_oil_ff) begin
         so_c = so_rem[FW+1] ? '0 : so_rem[FW-1:0];
      end
   end

   always_comb begin
      mul_state = (state_ff == cmga_pkg::ST_MO) || (state_ff == cmga_pkg::ST_MG)
               || (state_ff == cmga_pkg::ST_MW) || (state_ff == cmga_pkg::ST_MPV)
               || (state_ff == cmga_pkg::ST_SQX) || (state_ff == cmga_pkg::ST_SQY)
               || (state_ff == cmga_pkg::ST_SQZ) || (state_ff == cmga_pkg::ST_AZK)
               || (state_ff == cmga_pkg::ST_NUM) || (state_ff == cmga_pkg::ST_D3);
      mul_start  = launch_ff && mul_state;
      sqrt_start = launch_ff && (state_ff == cmga_pkg::ST_SQRT);
      div_start  = launch_ff && (state_ff == cmga_pkg::ST_DIV);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         cmga_pkg::ST_MO: begin
            mul_a = AW'(so_c);
            mul_b = BW'(od_ff);
         end
         cmga_pkg::ST_MG: begin
            mul_a = AW'(sg_c);
            mul_b = BW'(gd_ff);
         end
         cmga_pkg::ST_MW: begin
            mul_a = AW'(sw_c);
            mul_b = BW'(wd_ff);
         end
         cmga_pkg::ST_MPV: begin
            mul_a = AW'(pv_ff);
            mul_b = BW'(w_ff);
         end
         cmga_pkg::ST_SQX: begin
            mul_a = AW'(ax_ff);
            mul_b = BW'(ax_ff);
         end
         cmga_pkg::ST_SQY: begin
            mul_a = AW'(ay_ff);
            mul_b = BW'(ay_ff);
         end
         cmga_pkg::ST_SQZ: begin
            mul_a = AW'(az_ff);
            mul_b = BW'(az_ff);
         end
         cmga_pkg::ST_AZK: begin
            mul_a = AW'(az_ff);
            mul_b = BW'(cmga_pkg::GRAV_SCALE);
         end
         cmga_pkg::ST_NUM: begin
            mul_a = AW'(dm_mag_ff);
            mul_b = azk_ff;
         end
         cmga_pkg::ST_D3: begin
            mul_a = AW'(d2_ff);
            mul_b = BW'(r_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // arithmetic on the head station
   always_comb begin
      mass    = mul_p[MSW+8:9];
      dm      = $signed({1'b0, mass}) - $signed({1'b0, first_ff});
      dx      = $signed({px_ff[PW-1], px_ff}) - $signed({head.east[PW-1], head.east});
      dy      = $signed({py_ff[PW-1], py_ff}) - $signed({head.north[PW-1], head.north});
      dz      = $signed({pz_ff[PW-1], pz_ff}) - $signed({head.depth[PW-1], head.depth});
      d2_sum  = d2_ff + mul_p[D2W-1:0];
      root_p1 = {1'b0, root} + 1'b1;
      term    = (dm_neg_ff ^ dz_neg_ff) ? -$signed({1'b0, div_quot})
                                        : $signed({1'b0, div_quot});
      acc_sum = $signed({{2{head.sum[UW-1]}}, head.sum}) + $signed({term[UW], term});
      if ((acc_sum[UW+1:UW-1] == 3'b000) || (acc_sum[UW+1:UW-1] == 3'b111)) begin
         new_sum = acc_sum[UW-1:0];
      end else if (acc_sum[UW+1]) begin
         new_sum = {1'b1, {(UW-1){1'b0}}};
      end else begin
         new_sum = {1'b0, {(UW-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      has_gas_in   = has_gas_ff;
      has_oil_in   = has_oil_ff;
      gas_given_in = gas_given_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      swr_in       = swr_ff;
      sgr_in       = sgr_ff;
      od_in        = od_ff;
      gd_in        = gd_ff;
      wd_in        = wd_ff;
      pv_in        = pv_ff;
      head_in      = head_ff;
      stn_in       = stn_ff;
      n_in         = n_ff;
      w_in         = w_ff;
      first_in     = first_ff;
      dm_mag_in    = dm_mag_ff;
      dm_neg_in    = dm_neg_ff;
      dz_neg_in    = dz_neg_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      d2_in        = d2_ff;
      r_in         = r_ff;
      azk_in       = azk_ff;
      num_in       = num_ff;
      d3_in        = d3_ff;
      res_stn_in   = res_stn_ff;
      res_gc_in    = res_gc_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stn_in   = rsp_stn_ff;
      rsp_gc_in    = rsp_gc_ff;
      rsp_st_in    = rsp_st_ff;
      shift_ring   = 1'b0;
      wr_head      = 1'b0;
      wr_data      = head;
      req_ready    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            cmga_pkg::CSR_HAS_GAS:   has_gas_in   = csr_wdata[0];
            cmga_pkg::CSR_HAS_OIL:   has_oil_in   = csr_wdata[0];
            cmga_pkg::CSR_GAS_GIVEN: gas_given_in = csr_wdata[0];
            cmga_pkg::CSR_COUNT:     count_in     = csr_wdata;
            default:                 count_in     = count_ff;
         endcase
      end

      case (state_ff)
         cmga_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = cmga_pkg::cmd_type'(req_command);
               idx_in = req_station_index;
               px_in  = req_pos_x;
               py_in  = req_pos_y;
               pz_in  = req_pos_z;
               swr_in = req_water_sat;
               sgr_in = req_gas_sat;
               od_in  = req_oil_density;
               gd_in  = req_gas_density;
               wd_in  = req_water_density;
               pv_in  = req_pore_volume;
               tgt_in = '0;
               case (cmga_pkg::cmd_type'(req_command))
                  cmga_pkg::CMD_LOAD, cmga_pkg::CMD_READ: begin
                     tgt_in   = req_station_index;
                     state_in = cmga_pkg::ST_SEEK;
                  end
                  default: begin
                     if (!req_aquifer_cell) begin
                        state_in = cmga_pkg::ST_MO;
                     end
                  end
               endcase
            end
         end
         cmga_pkg::ST_SEEK: begin
            if (head_ff != tgt_ff) begin
               shift_ring = 1'b1;
               head_in    = head_ff + 1'b1;
            end else begin
               case (cmd_ff)
                  cmga_pkg::CMD_LOAD: begin
                     wr_head       = 1'b1;
                     wr_data.east  = px_ff;
                     wr_data.north = py_ff;
                     wr_data.depth = pz_ff;
                     wr_data.sum   = '0;
                     state_in      = cmga_pkg::ST_IDLE;
                  end
                  cmga_pkg::CMD_READ: begin
                     res_stn_in = idx_ff;
                     res_gc_in  = head.sum;
                     res_st_in  = cmga_pkg::STATUS_DATA;
                     state_in   = cmga_pkg::ST_EMIT;
                  end
                  default: begin
                     stn_in   = '0;
                     state_in = cmga_pkg::ST_DIFF;
                  end
               endcase
            end
         end
         cmga_pkg::ST_MO: begin
            if (mul_done) begin
               w_in     = mul_p[cmga_pkg::WDEN_W-1:0];
               state_in = cmga_pkg::ST_MG;
            end
         end
         cmga_pkg::ST_MG: begin
            if (mul_done) begin
               w_in     = w_ff + mul_p[cmga_pkg::WDEN_W-1:0];
               state_in = cmga_pkg::ST_MW;
            end
         end
         cmga_pkg::ST_MW: begin
            if (mul_done) begin
               w_in     = w_ff + mul_p[cmga_pkg::WDEN_W-1:0];
               state_in = cmga_pkg::ST_MPV;
            end
         end
         cmga_pkg::ST_MPV: begin
            if (mul_done) begin
               if (cmd_ff == cmga_pkg::CMD_CELL1) begin
                  first_in = mass;
                  state_in = cmga_pkg::ST_IDLE;
               end else begin
                  dm_neg_in = dm[MSW];
                  dm_mag_in = dm[MSW] ? MSW'(-dm) : dm[MSW-1:0];
                  n_in      = (count_ff > cmga_pkg::CNT_W'(NS)) ? cmga_pkg::CNT_W'(NS)
                                                                : count_ff;
                  state_in  = (count_ff == '0) ? cmga_pkg::ST_IDLE : cmga_pkg::ST_SEEK;
               end
            end
         end
         cmga_pkg::ST_DIFF: begin
            ax_in     = dx[DFW-1] ? DFW'(-dx) : dx;
            ay_in     = dy[DFW-1] ? DFW'(-dy) : dy;
            az_in     = dz[DFW-1] ? DFW'(-dz) : dz;
            dz_neg_in = dz[DFW-1];
            state_in  = cmga_pkg::ST_SQX;
         end
         cmga_pkg::ST_SQX: begin
            if (mul_done) begin
               d2_in    = mul_p[D2W-1:0];
               state_in = cmga_pkg::ST_SQY;
            end
         end
         cmga_pkg::ST_SQY: begin
            if (mul_done) begin
               d2_in    = d2_sum;
               state_in = cmga_pkg::ST_SQZ;
            end
         end
         cmga_pkg::ST_SQZ: begin
            if (mul_done) begin
               d2_in = d2_sum;
               if (d2_sum == '0) begin
                  res_stn_in = stn_ff;
                  res_gc_in  = '0;
                  res_st_in  = cmga_pkg::STATUS_FAULT;
                  state_in   = cmga_pkg::ST_EMIT;
               end else begin
                  state_in = cmga_pkg::ST_SQRT;
               end
            end
         end
         cmga_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               r_in     = root_p1[RDW:1];
               state_in = cmga_pkg::ST_AZK;
            end
         end
         cmga_pkg::ST_AZK: begin
            if (mul_done) begin
               azk_in   = mul_p[BW-1:0];
               state_in = cmga_pkg::ST_NUM;
            end
         end
         cmga_pkg::ST_NUM: begin
            if (mul_done) begin
               num_in   = mul_p;
               state_in = cmga_pkg::ST_D3;
            end
         end
         cmga_pkg::ST_D3: begin
            if (mul_done) begin
               d3_in    = mul_p;
               state_in = cmga_pkg::ST_DIV;
            end
         end
         cmga_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = cmga_pkg::ST_ACC;
            end
         end
         cmga_pkg::ST_ACC: begin
            wr_head     = 1'b1;
            wr_data.sum = new_sum;
            if (({1'b0, stn_ff} + 1'b1) == n_ff) begin
               state_in = cmga_pkg::ST_IDLE;
            end else begin
               state_in = cmga_pkg::ST_NEXT;
            end
         end
         cmga_pkg::ST_NEXT: begin
            shift_ring = 1'b1;
            head_in    = head_ff + 1'b1;
            stn_in     = stn_ff + 1'b1;
            state_in   = cmga_pkg::ST_DIFF;
         end
         cmga_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stn_in   = res_stn_ff;
               rsp_gc_in    = res_gc_ff;
               rsp_st_in    = res_st_ff;
               state_in     = cmga_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmga_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmga_pkg::ST_IDLE;
         launch_ff    <= 1'b0;
         has_gas_ff   <= 1'b0;
         has_oil_ff   <= 1'b1;
         gas_given_ff <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= (state_in != state_ff);
         has_gas_ff   <= has_gas_in;
         has_oil_ff   <= has_oil_in;
         gas_given_ff <= gas_given_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      tgt_ff     <= tgt_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pz_ff      <= pz_in;
      swr_ff     <= swr_in;
      sgr_ff     <= sgr_in;
      od_ff      <= od_in;
      gd_ff      <= gd_in;
      wd_ff      <= wd_in;
      pv_ff      <= pv_in;
      stn_ff     <= stn_in;
      n_ff       <= n_in;
      w_ff       <= w_in;
      dm_mag_ff  <= dm_mag_in;
      dm_neg_ff  <= dm_neg_in;
      dz_neg_ff  <= dz_neg_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      az_ff      <= az_in;
      d2_ff      <= d2_in;
      r_ff       <= r_in;
      azk_ff     <= azk_in;
      num_ff     <= num_in;
      d3_ff      <= d3_in;
      res_stn_ff <= res_stn_in;
      res_gc_ff  <= res_gc_in;
      res_st_ff  <= res_st_in;
      rsp_stn_ff <= rsp_stn_in;
      rsp_gc_ff  <= rsp_gc_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_station = rsp_stn_ff;
   assign rsp_gravity_change = rsp_gc_ff;
   assign rsp_status         = rsp_st_ff;

   a_mul_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> mul_state)
      else $error("multiplier finished outside a multiply step");

   a_one_unit_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done, sqrt_done, div_done}))
      else $error("more than one arithmetic unit finished at once");

   a_load_blocks_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == cmga_pkg::CMD_LOAD)) |=> !req_ready)
      else $error("transfer taken while a load is in progress");

   a_fault_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cmga_pkg::STATUS_FAULT)) |-> (rsp_gravity_change == '0))
      else $error("fault result carries a non-zero value");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS    = cmga_pkg::MAX_STATIONS;
   localparam int STN_W = cmga_pkg::STN_W;
   localparam int POS_W = cmga_pkg::POS_W;
   localparam int SAT_W = cmga_pkg::SAT_W;
   localparam int DEN_W = cmga_pkg::DEN_W;
   localparam int PV_W  = cmga_pkg::PV_W;
   localparam int CNT_W = cmga_pkg::CNT_W;
   localparam int MSW   = cmga_pkg::MASS_W;
   localparam int UW    = cmga_pkg::SUM_W;

   localparam int LIMIT_CYCLES = 20_000_000;
   localparam int DRAIN_CYCLES = 5000;
   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      cmga_pkg::cmd_type       cmd;
      logic [STN_W-1:0]        idx;
      logic signed [POS_W-1:0] px, py, pz;
      logic signed [SAT_W-1:0] ws, gs;
      logic [DEN_W-1:0]        od, gd, wd;
      logic [PV_W-1:0]         pv;
      logic                    aq;
   } item_type;

   typedef struct {
      logic [STN_W-1:0]  stn;
      logic signed [63:0] change;
      logic              status;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [STN_W-1:0] req_station_index = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [SAT_W-1:0] req_water_sat = '0, req_gas_sat = '0;
   logic [DEN_W-1:0] req_oil_density = '0, req_gas_density = '0, req_water_density = '0;
   logic [PV_W-1:0] req_pore_volume = '0;
   logic req_aquifer_cell = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STN_W-1:0] rsp_result_station;
   logic signed [UW-1:0] rsp_gravity_change;
   logic rsp_status;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [CNT_W-1:0] csr_wdata = '0;

   cell_mass_gravity_accumulator i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic signed [POS_W-1:0] stn_e [NS];
   logic signed [POS_W-1:0] stn_n [NS];
   logic signed [POS_W-1:0] stn_d [NS];
   logic signed [63:0]      stn_sum [NS];
   logic [MSW-1:0]          first_mass = '0;
   logic has_gas = 1'b0, has_oil = 1'b1, gas_given = 1'b0;
   logic [CNT_W-1:0] stn_count = '0;

   // generation-time copy of station positions
   logic signed [POS_W-1:0] gen_e [NS];
   logic signed [POS_W-1:0] gen_n [NS];
   logic signed [POS_W-1:0] gen_d [NS];

   item_type   pending_items[$];
   result_type expected_results[$];
   item_type   on_bus;
   int      errors = 0;
   int      cycles = 0;
   bit      idle_on = 1'b1;
   bit      hold_go = 1'b0;
   int      req_gap = 0, rsp_stall = 0, hold_cnt = 0;

   initial for (int i = 0; i < NS; i++) stn_sum[i] = '0;

   function automatic logic signed [31:0] clamp_sat(logic signed [31:0] s);
      return s < 0 ? 32'sd0 : (s > 65536 ? 32'sd65536 : s);
   endfunction

   function automatic logic [MSW-1:0] mass_of(item_type it);
      logic signed [31:0] sw, sg, so;
      logic [127:0] w, m;
      sw = clamp_sat(32'(it.ws));
      sg = 32'sd0;
      so = 32'sd0;
      if (has_gas) sg = gas_given ? clamp_sat(32'(it.gs)) : 32'sd65536 - sw;
      if (has_oil) so = clamp_sat(32'sd65536 - sg - sw);
      w = 128'(so) * 128'(it.od) + 128'(sg) * 128'(it.gd) + 128'(sw) * 128'(it.wd);
      m = (128'(it.pv) * w) >> 9;
      return m[MSW-1:0];
   endfunction

   function automatic logic [63:0] root_of(logic [127:0] x);
      logic [127:0] r, t;
      r = '0;
      for (int b = 43; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= x) r = t;
      end
      return r[63:0];
   endfunction

   function automatic void gravity_predict(item_type it);
      logic signed [63:0] dm, dx, dy, dz, t, acc;
      logic [63:0] ax, ay, az, adm, r, q;
      logic [127:0] d2, d3, num;
      logic [255:0] qf;
      int n;
      result_type res;
      case (it.cmd)
         cmga_pkg::CMD_LOAD: begin
            stn_e[it.idx] = it.px;
            stn_n[it.idx] = it.py;
            stn_d[it.idx] = it.pz;
            stn_sum[it.idx] = '0;
         end
         cmga_pkg::CMD_READ: begin
            res.stn = it.idx;
            res.change = stn_sum[it.idx];
            res.status = cmga_pkg::STATUS_DATA;
            expected_results.push_back(res);
         end
         default: begin
            if (!it.aq) begin
               if (it.cmd == cmga_pkg::CMD_CELL1) first_mass = mass_of(it);
               else begin
                  dm = $signed(64'(mass_of(it))) - $signed(64'(first_mass));
                  adm = dm < 0 ? -dm : dm;
                  n = stn_count > NS ? NS : int'(stn_count);
                  for (int s = 0; s < n; s++) begin
                     dx = 64'(it.px) - 64'(stn_e[s]);
                     dy = 64'(it.py) - 64'(stn_n[s]);
                     dz = 64'(it.pz) - 64'(stn_d[s]);
                     ax = dx < 0 ? -dx : dx;
                     ay = dy < 0 ? -dy : dy;
                     az = dz < 0 ? -dz : dz;
                     d2 = 128'(ax) * ax + 128'(ay) * ay + 128'(az) * az;
                     if (d2 == 0) begin
                        res.stn = s[STN_W-1:0];
                        res.change = '0;
                        res.status = cmga_pkg::STATUS_FAULT;
                        expected_results.push_back(res);
                        break;
                     end
                     r = (root_of(d2 << 2) + 64'd1) >> 1;
                     d3 = d2 * 128'(r);
                     num = 128'(adm) * 128'(az * 64'(cmga_pkg::GRAV_SCALE));
                     qf = (256'(num) << cmga_pkg::FRAC_EXTRA) / 256'(d3);
                     q = qf > 256'(SUM_MAX) ? SUM_MAX : qf[63:0];
                     t = ((dm < 0) != (dz < 0)) ? -$signed(q) : $signed(q);
                     acc = stn_sum[s];
                     if (t > 0 && acc > SUM_MAX - t) acc = SUM_MAX;
                     else if (t < 0 && acc < SUM_MIN - t) acc = SUM_MIN;
                     else acc = acc + t;
                     stn_sum[s] = acc;
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] rand_pos();
      if ($urandom_range(0, 7) == 0) return POS_W'({$urandom, $urandom});
      return POS_W'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
   endfunction

   function automatic logic signed [SAT_W-1:0] rand_sat();
      if ($urandom_range(0, 5) == 0) return SAT_W'($urandom);
      return SAT_W'($urandom_range(0, 65536));
   endfunction

   function automatic item_type make_item(cmga_pkg::cmd_type c);
      item_type it;
      it.cmd = c;
      it.idx = STN_W'($urandom);
      it.px = rand_pos();
      it.py = rand_pos();
      it.pz = rand_pos();
      it.ws = rand_sat();
      it.gs = rand_sat();
      it.od = DEN_W'($urandom);
      it.gd = DEN_W'($urandom);
      it.wd = DEN_W'($urandom);
      it.pv = PV_W'($urandom);
      it.aq = 1'b0;
      return it;
   endfunction

   function automatic void push_load(item_type it);
      gen_e[it.idx] = it.px;
      gen_n[it.idx] = it.py;
      gen_d[it.idx] = it.pz;
      pending_items.push_back(it);
   endfunction

   function automatic void push_random(int count, int swept);
      item_type a, b;
      int p, k, done;
      done = 0;
      while (done < count) begin
         p = $urandom_range(0, 99);
         if (p < 60) begin
            a = make_item(cmga_pkg::CMD_CELL1);
            b = make_item(cmga_pkg::CMD_CELL2);
            if ($urandom_range(0, 1)) begin
               b.px = a.px;
               b.py = a.py;
               b.pz = a.pz;
            end
            if (swept > 0 && $urandom_range(0, 19) == 0) begin
               k = $urandom_range(0, swept - 1);
               b.px = gen_e[k];
               b.py = gen_n[k];
               b.pz = gen_d[k];
            end
            pending_items.push_back(a);
            pending_items.push_back(b);
            done += 2;
         end else if (p < 72) begin
            pending_items.push_back(make_item(cmga_pkg::CMD_READ));
            done++;
         end else if (p < 80) begin
            push_load(make_item(cmga_pkg::CMD_LOAD));
            done++;
         end else if (p < 86) begin
            pending_items.push_back(make_item(cmga_pkg::CMD_CELL1));
            done++;
         end else if (p < 92) begin
            pending_items.push_back(make_item(cmga_pkg::CMD_CELL2));
            done++;
         end else begin
            a = make_item($urandom_range(0, 1) ? cmga_pkg::CMD_CELL1 : cmga_pkg::CMD_CELL2);
            a.aq = 1'b1;
            pending_items.push_back(a);
         end
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) gravity_predict(on_bus);
         if (!(req_valid && !req_ready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               on_bus = pending_items.pop_front();
               req_command <= on_bus.cmd;
               req_station_index <= on_bus.idx;
               req_pos_x <= on_bus.px;
               req_pos_y <= on_bus.py;
               req_pos_z <= on_bus.pz;
               req_water_sat <= on_bus.ws;
               req_gas_sat <= on_bus.gs;
               req_oil_density <= on_bus.od;
               req_gas_density <= on_bus.gd;
               req_water_density <= on_bus.wd;
               req_pore_volume <= on_bus.pv;
               req_aquifer_cell <= on_bus.aq;
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type e;
      cycles++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transfer: stn %0d change %0d status %0d",
                           rsp_result_station, rsp_gravity_change, rsp_status);
            end else begin
               e = expected_results.pop_front();
               if (rsp_result_station !== e.stn || rsp_gravity_change !== e.change ||
                   rsp_status !== e.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp stn %0d change %0d status %0d, got %0d %0d %0d",
                              e.stn, e.change, e.status, rsp_result_station,
                              rsp_gravity_change, rsp_status);
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (hold_go) begin
            hold_go = 1'b0;
            hold_cnt = 3000;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 13);
         end
      end
   end

   initial begin
      while (cycles < LIMIT_CYCLES) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic write_regs(logic g, logic o, logic gv, logic [CNT_W-1:0] c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= cmga_pkg::CSR_HAS_GAS;
      csr_wdata <= CNT_W'(g);
      has_gas = g;
      @(posedge clock);
      csr_index <= cmga_pkg::CSR_HAS_OIL;
      csr_wdata <= CNT_W'(o);
      has_oil = o;
      @(posedge clock);
      csr_index <= cmga_pkg::CSR_GAS_GIVEN;
      csr_wdata <= CNT_W'(gv);
      gas_given = gv;
      @(posedge clock);
      csr_index <= cmga_pkg::CSR_COUNT;
      csr_wdata <= c;
      stn_count = c;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      item_type it;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_regs(1'b1, 1'b1, 1'b1, 5'd4);

      for (int i = 0; i < NS; i++) begin
         it = make_item(cmga_pkg::CMD_LOAD);
         it.idx = STN_W'(i);
         if (i == 0) begin
            it.px = {1'b0, {(POS_W-1){1'b1}}};
            it.py = it.px;
            it.pz = it.px;
         end else if (i == 1) begin
            it.px = {1'b1, {(POS_W-1){1'b0}}};
            it.py = it.px;
            it.pz = it.px;
         end
         push_load(it);
      end
      it = make_item(cmga_pkg::CMD_READ);
      it.idx = STN_W'(5);
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_CELL1);
      it.ws = {1'b1, {(SAT_W-1){1'b0}}};
      it.gs = {1'b0, {(SAT_W-1){1'b1}}};
      it.od = '1;
      it.gd = '1;
      it.wd = '1;
      it.pv = '1;
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_CELL2);
      it.px = {1'b1, {(POS_W-1){1'b0}}};
      it.py = '0;
      it.pz = '0;
      it.ws = {1'b0, {(SAT_W-1){1'b1}}};
      it.gs = '0;
      it.pv = '1;
      pending_items.push_back(it);
      for (int i = 0; i < 4; i++) begin
         it = make_item(cmga_pkg::CMD_READ);
         it.idx = STN_W'(i);
         pending_items.push_back(it);
      end
      // zero distance on station 2
      it = make_item(cmga_pkg::CMD_CELL2);
      it.px = gen_e[2];
      it.py = gen_n[2];
      it.pz = gen_d[2];
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_CELL2);
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_CELL1);
      it.aq = 1'b1;
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_CELL2);
      it.aq = 1'b1;
      pending_items.push_back(it);
      it = make_item(cmga_pkg::CMD_READ);
      it.idx = STN_W'(3);
      pending_items.push_back(it);
      drain();

      write_regs(1'b0, 1'b1, 1'b0, 5'd1);
      hold_go = 1'b1;
      for (int i = 0; i < 10; i++) pending_items.push_back(make_item(cmga_pkg::CMD_READ));
      push_random(80, 1);
      drain();

      write_regs(1'b1, 1'b1, 1'b0, 5'd16);
      push_random(90, 16);
      drain();

      write_regs(1'b1, 1'b0, 1'b1, 5'd0);
      push_random(90, 0);
      drain();

      write_regs(1'b0, 1'b0, 1'b0, 5'd17);
      push_random(80, 16);
      drain();

      write_regs(1'b1, 1'b1, 1'b1, 5'd31);
      push_random(70, 16);
      drain();

      write_regs(1'b1, 1'b1, 1'b1, 5'd2);
      idle_on = 1'b0;
      push_random(90, 2);
      drain();

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
